// File: design/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and fixed constants of the go-back-N sender window block.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Field widths fixed by the interface
    localparam int WIN_CFG_W    = 6;
    localparam int FILE_W       = 32;
    localparam int REQLEN_W     = 11;
    localparam int ACT_W        = 2;
    localparam int NUM_W        = 32;
    localparam int LEN_W        = 11;
    localparam int IDX_W        = 23;
    localparam int RESULT_LIMIT = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // Action codes of an input transaction
    localparam logic [ACT_W-1:0] ACT_START   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACK     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REQLEN = 2'd2;

    localparam logic [WIN_CFG_W-1:0] WIN_RESET = 6'd4;

    // Connection phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_XFER   = 2'd1,
        PH_FINW   = 2'd2,
        PH_CLOSED = 2'd3
    } t_phase;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CALC  = 6'b000010,
        S_SETUP = 6'b000100,
        S_RANGE = 6'b001000,
        S_SEND  = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    // Sequencer to segment unit
    typedef struct packed {
        logic load;
        logic step;
    } t_seg_cmd;

    // Segment unit to sequencer
    typedef struct packed {
        logic busy;
        logic last;
    } t_seg_sts;

endpackage

// File: design/gbn_seg_unit.sv
// ----------------------------------------------------------------------------
// gbn_seg_unit
// Segment index walker: one shared incrementer and its compares stepping through
// a range of segments, producing byte offset, length and last marker.
// ----------------------------------------------------------------------------
module gbn_seg_unit #(
    parameter int CNT_W     = 23,
    parameter int SEG_SHIFT = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gbn_pkg::t_seg_cmd             i_cmd,
    input  logic [gbn_pkg::IDX_W-1:0]     i_from,
    input  logic [CNT_W-1:0]              i_end,
    input  logic [CNT_W-1:0]              i_nseg,
    input  logic [SEG_SHIFT-1:0]          i_rem,
    output gbn_pkg::t_seg_sts             o_sts,
    output logic [gbn_pkg::NUM_W-1:0]     o_seq,
    output logic [gbn_pkg::LEN_W-1:0]     o_len
);
    import gbn_pkg::*;

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(1 << SEG_SHIFT);

    logic                          r_busy;
    logic [CNT_W-1:0]              r_idx;
    logic [CNT_W-1:0]              r_end;
    logic [CNT_W-1:0]              r_nseg;
    logic [SEG_SHIFT-1:0]          r_rem;
    logic [CNT_W-1:0]              idx_next;
    logic                          is_last;
    logic                          is_short;
    logic [CNT_W+SEG_SHIFT-1:0]    byte_off;

    // Shared incrementer and its compares
    assign idx_next = r_idx + CNT_W'(1);
    assign is_last  = (idx_next == r_end);
    assign is_short = (idx_next == r_nseg) && (r_rem != '0);
    assign byte_off = {r_idx, {SEG_SHIFT{1'b0}}};

    assign o_seq      = byte_off[NUM_W-1:0];
    assign o_len      = is_short ? LEN_W'(r_rem) : FULL_LEN;
    assign o_sts.busy = r_busy;
    assign o_sts.last = is_last;

    // Walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.load) begin
            r_busy <= 1'b1;
        end else if (i_cmd.step && is_last) begin
            r_busy <= 1'b0;
        end
    end

    // Range registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx  <= CNT_W'(i_from);
            r_end  <= i_end;
            r_nseg <= i_nseg;
            r_rem  <= i_rem;
        end else if (i_cmd.step) begin
            r_idx <= idx_next;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_end))
        else $error("segment index ran past range end");

endmodule

// File: design/go_back_n_sender_window_top.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window_top
// Go-back-N sender window controller: turns start, acknowledgement and
// timeout transactions into a stream of data and FIN send commands.
// ----------------------------------------------------------------------------
// The input transaction is captured, then passes the CALC, SETUP and RANGE states;
// results are registered into the output register from the SEND or FIN state. An item
// holds the block until its results are out, one per cycle from the walker unless the output stalls.
// The output register lets a new item be taken while a result waits.
// Reset: synchronous active low; phase idle, window empty, config defaults.
module go_back_n_sender_window_top #(
    parameter int SEGMENT_BYTES = 1024,
    parameter int MAX_WINDOW    = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [gbn_pkg::ACT_W-1:0]         i_action,
    input  logic [gbn_pkg::NUM_W-1:0]         i_ack_number,
    input  logic [gbn_pkg::NUM_W-1:0]         i_peer_seq,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [gbn_pkg::NUM_W-1:0]         o_seq_number,
    output logic [gbn_pkg::NUM_W-1:0]         o_ack_field,
    output logic                              o_fin_flag,
    output logic [gbn_pkg::LEN_W-1:0]         o_payload_length,
    output logic                              o_last,
    output logic                              o_closed
);
    import gbn_pkg::*;

    localparam int SEG_SHIFT = $clog2(SEGMENT_BYTES);
    localparam int NSEG_W    = FILE_W + 1 - SEG_SHIFT;
    localparam int CNT_W     = (NSEG_W > IDX_W) ? NSEG_W : IDX_W;
    localparam int EFF_CAP   = (MAX_WINDOW < RESULT_LIMIT) ? MAX_WINDOW : RESULT_LIMIT;
    localparam int WIN_W     = $clog2(EFF_CAP + 1);
    localparam logic [FILE_W:0] SEG_ROUND = (FILE_W + 1)'(SEGMENT_BYTES - 1);

    // Configuration registers
    logic [WIN_CFG_W-1:0] r_window_size;
    logic [FILE_W-1:0]    r_file_size;
    logic [REQLEN_W-1:0]  r_request_length;

    // Connection state
    t_state               r_state;
    t_state               n_state;
    t_phase               r_phase;
    logic [IDX_W-1:0]     r_head;
    logic [IDX_W-1:0]     r_tail;
    logic [NUM_W-1:0]     r_fin_seq_saved;
    logic [NUM_W-1:0]     r_fin_ack_saved;

    // Latched transaction and working values
    logic [ACT_W-1:0]     r_action;
    logic [NUM_W-1:0]     r_ackn;
    logic [NUM_W-1:0]     r_pseq;
    logic [NSEG_W-1:0]    r_req;
    logic [NSEG_W-1:0]    r_nseg;
    logic [SEG_SHIFT-1:0] r_rem;
    logic [WIN_W-1:0]     r_w;
    logic [IDX_W-1:0]     r_from;
    logic [IDX_W-1:0]     r_to;
    logic [NUM_W-1:0]     r_pend_seq;
    logic [NUM_W-1:0]     r_pend_ack;
    logic                 r_pend_cls;

    // Output register
    logic                 r_out_valid;
    logic [NUM_W-1:0]     r_out_seq;
    logic [NUM_W-1:0]     r_out_ack;
    logic                 r_out_fin;
    logic [LEN_W-1:0]     r_out_len;
    logic                 r_out_last;
    logic                 r_out_cls;

    logic                 in_acc;
    logic                 out_adv;
    logic [WIN_W-1:0]     w_eff;
    logic [IDX_W-1:0]     req_cl;
    logic                 slide;
    logic [IDX_W-1:0]     slid_tail;
    logic [CNT_W-1:0]     range_end;
    logic                 range_some;
    logic                 xfer_done;
    logic                 go_send;
    logic                 send_out;
    logic                 fin_out;
    t_seg_cmd             seg_cmd;
    t_seg_sts             seg_sts;
    logic [NUM_W-1:0]     seg_seq;
    logic [LEN_W-1:0]     seg_len;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_adv    = !r_out_valid || i_out_ready;

    // Effective window: zero acts as one, large values saturate
    always_comb begin
        if (r_window_size == '0) begin
            w_eff = WIN_W'(1);
        end else if (r_window_size > WIN_CFG_W'(EFF_CAP)) begin
            w_eff = WIN_W'(EFF_CAP);
        end else begin
            w_eff = WIN_W'(r_window_size);
        end
    end

    // Acknowledged segment clamped to tail, and window slide
    always_comb begin
        if (CNT_W'(r_req) > CNT_W'(r_tail)) begin
            req_cl = r_tail;
        end else begin
            req_cl = IDX_W'(r_req);
        end
        slide     = (req_cl > r_head);
        slid_tail = slide ? (req_cl + IDX_W'(r_w)) : r_tail;
    end

    // Range end limited to the segment count
    always_comb begin
        if (CNT_W'(r_to) < CNT_W'(r_nseg)) begin
            range_end = CNT_W'(r_to);
        end else begin
            range_end = CNT_W'(r_nseg);
        end
        range_some = (CNT_W'(r_from) < range_end);
        xfer_done  = (r_action == ACT_ACK) && (r_phase == PH_XFER)
                     && (CNT_W'(r_head) >= CNT_W'(r_nseg));
        go_send    = range_some && !xfer_done
                     && ((r_action == ACT_START)
                         || (((r_action == ACT_ACK) || (r_action == ACT_TIMEOUT))
                             && (r_phase == PH_XFER)));
    end

    assign send_out     = (r_state == S_SEND) && out_adv;
    assign fin_out      = (r_state == S_FIN) && out_adv;
    assign seg_cmd.load = (r_state == S_RANGE) && go_send;
    assign seg_cmd.step = send_out;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CALC;
                end
            end
            S_CALC:  n_state = S_SETUP;
            S_SETUP: n_state = S_RANGE;
            S_RANGE: begin
                if (xfer_done) begin
                    n_state = (r_ackn == r_file_size) ? S_FIN : S_IDLE;
                end else if (go_send) begin
                    n_state = S_SEND;
                end else if ((r_phase == PH_FINW)
                             && ((r_action == ACT_ACK) || (r_action == ACT_TIMEOUT))) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SEND: begin
                if (send_out && seg_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                if (fin_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size    <= WIN_RESET;
            r_file_size      <= '0;
            r_request_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW: r_window_size    <= i_cfg_data[WIN_CFG_W-1:0];
                CFG_FILE:   r_file_size      <= i_cfg_data[FILE_W-1:0];
                CFG_REQLEN: r_request_length <= i_cfg_data[REQLEN_W-1:0];
                default:    ;
            endcase
        end
    end

    // Capture of the input transaction
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_action;
            r_ackn   <= i_ack_number;
            r_pseq   <= i_peer_seq;
        end
    end

    // Segment rounding and effective window
    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC) begin
            r_req  <= NSEG_W'(({1'b0, r_ackn} + SEG_ROUND) >> SEG_SHIFT);
            r_nseg <= NSEG_W'(({1'b0, r_file_size} + SEG_ROUND) >> SEG_SHIFT);
            r_rem  <= r_file_size[SEG_SHIFT-1:0];
            r_w    <= w_eff;
        end
    end

    // Window update and send range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_head          <= '0;
            r_tail          <= '0;
            r_fin_seq_saved <= '0;
            r_fin_ack_saved <= '0;
        end else if (r_state == S_SETUP) begin
            case (r_action)
                ACT_START: begin
                    r_phase <= PH_XFER;
                    r_head  <= '0;
                    r_tail  <= IDX_W'(r_w);
                    r_from  <= '0;
                    r_to    <= IDX_W'(r_w);
                end
                ACT_ACK: begin
                    r_from <= r_tail;
                    r_to   <= slid_tail;
                    if ((r_phase == PH_XFER) && slide) begin
                        r_head <= req_cl;
                        r_tail <= slid_tail;
                    end
                end
                ACT_TIMEOUT: begin
                    r_from <= r_head;
                    r_to   <= r_tail;
                end
                default: ;
            endcase
        end else if (r_state == S_RANGE) begin
            if (xfer_done) begin
                r_phase         <= PH_FINW;
                r_head          <= '0;
                r_tail          <= IDX_W'(r_w);
                r_fin_seq_saved <= r_ackn;
                r_fin_ack_saved <= r_pseq + NUM_W'(1);
            end else if ((r_action == ACT_ACK) && (r_phase == PH_FINW)) begin
                r_phase <= PH_CLOSED;
            end
        end
    end

    // Pending FIN packet
    always_ff @(posedge i_clk) begin
        if (r_state == S_RANGE) begin
            if ((r_action == ACT_TIMEOUT) && (r_phase == PH_FINW)) begin
                r_pend_seq <= r_fin_seq_saved;
                r_pend_ack <= r_fin_ack_saved;
                r_pend_cls <= 1'b0;
            end else begin
                r_pend_seq <= r_ackn;
                r_pend_ack <= r_pseq + NUM_W'(1);
                r_pend_cls <= !xfer_done;
            end
        end
    end

    // Segment walker
    gbn_seg_unit #(
        .CNT_W     (CNT_W),
        .SEG_SHIFT (SEG_SHIFT)
    ) u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (seg_cmd),
        .i_from  (r_from),
        .i_end   (range_end),
        .i_nseg  (CNT_W'(r_nseg)),
        .i_rem   (r_rem),
        .o_sts   (seg_sts),
        .o_seq   (seg_seq),
        .o_len   (seg_len)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (send_out || fin_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (send_out) begin
            r_out_seq  <= seg_seq;
            r_out_ack  <= NUM_W'(r_request_length);
            r_out_fin  <= 1'b0;
            r_out_len  <= seg_len;
            r_out_last <= seg_sts.last;
            r_out_cls  <= 1'b0;
        end else if (fin_out) begin
            r_out_seq  <= r_pend_seq;
            r_out_ack  <= r_pend_ack;
            r_out_fin  <= 1'b1;
            r_out_len  <= '0;
            r_out_last <= 1'b1;
            r_out_cls  <= r_pend_cls;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_seq_number     = r_out_seq;
    assign o_ack_field      = r_out_ack;
    assign o_fin_flag       = r_out_fin;
    assign o_payload_length = r_out_len;
    assign o_last           = r_out_last;
    assign o_closed         = r_out_cls;

    // Checks
    a_fin_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fin) |-> (r_out_len == '0))
        else $error("FIN carries payload length");

    a_close_is_last_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cls) |-> (r_out_fin && r_out_last))
        else $error("close marker on a non-final or data packet");

    a_data_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_fin) |-> (r_out_seq[SEG_SHIFT-1:0] == '0))
        else $error("data offset not segment aligned");

    a_send_walker_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> seg_sts.busy)
        else $error("send state without active segment walk");

endmodule
